// ----- sv/aas_pkg.sv -----
package aas_pkg;

   // Field and datapath widths
   localparam int DATA_W     = 32;
   localparam int AXIS_W     = 3;
   localparam int AXES       = 6;
   localparam int DT_W       = 31;
   localparam int MUL_A_W    = DATA_W + 1;
   localparam int PROD_W     = 64;
   localparam int RND_W      = 48;
   localparam int SUM_W      = 50;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 6 * DATA_W;
   localparam int RSP_DATA_W = 4 * DATA_W;
   localparam int RSP_USER_W = AXIS_W + 1;

   // Rounding offset for Q32.32 -> Q16.16, half up
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_KPM  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BPM  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_IMASS = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DT   = 2'd3;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_KP0,
      ST_BV0,
      ST_DTV,
      ST_ACC,
      ST_DTA,
      ST_KP1,
      ST_BV1,
      ST_SUB1,
      ST_DONE
   } state_type;

   // Multiplier operand pair
   typedef enum logic [2:0] {
      MS_IMF,
      MS_KPOS,
      MS_BVEL,
      MS_DTV,
      MS_DTA
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        latch_in;   // capture request word
      logic        load_state; // fetch or seed deviation of the axis
      logic        ld_imf;     // sum = im*F
      logic        sub_prod;   // sum -= product
      logic        sat_acc;    // acc = sat(sum)
      logic        restart;    // sum = im*F again
      logic        upd_pos;    // pos = sat(pos + dt*vel)
      logic        upd_vel;    // vel = sat(vel + dt*acc)
      logic        finish;     // write back state, load output word
   } cmd_type;

   typedef struct packed {
      logic axis_ok;
   } stat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     clip;
   } sat_type;

   // Saturate a wide sum to 32 bit signed
   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type r;
      if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
         r.val  = v[DATA_W-1:0];
         r.clip = 1'b0;
      end else begin
         r.val  = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         r.clip = 1'b1;
      end
      return r;
   endfunction

endpackage

// ----- sv/admittance_axis_step_core.sv -----
// A request word is accepted in IDLE and steps through the sequencer to DONE,
// which loads the result word once the output is free; an axis index outside
// the range goes from LOAD straight to DONE. No new word is taken until then;
// the single shared 33x32 multiplier forms seven products per word in turn.
// Reset (synchronous, active high) restores register defaults and marks every
// axis as not started; the first word of an axis seeds its deviation.
module admittance_axis_step_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // des_pos, des_vel, act_pos, act_vel, act_force, des_force
   input  logic [aas_pkg::REQ_DATA_W-1:0]      req_tdata,
   // axis
   input  logic [aas_pkg::AXIS_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cmd_pos, cmd_vel, cmd_acc, cmd_force
   output logic [aas_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // out_axis, clipped
   output logic [aas_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                csr_we,
   input  logic [aas_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [aas_pkg::DATA_W-1:0]          csr_wdata
);
   import aas_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   aas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   aas_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- sv/aas_ctrl.sv -----
module aas_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  aas_pkg::stat_type stat,
   output aas_pkg::cmd_type  cmd
);
   import aas_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer: one product per cycle through the shared multiplier; DONE waits for a free output
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MS_IMF;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_state = 1'b1;
            cmd.mul_sel    = MS_IMF;
            state_in       = stat.axis_ok ? ST_KP0 : ST_DONE;
         end
         ST_KP0: begin
            cmd.mul_sel = MS_KPOS;
            cmd.ld_imf  = 1'b1;
            state_in    = ST_BV0;
         end
         ST_BV0: begin
            cmd.mul_sel  = MS_BVEL;
            cmd.sub_prod = 1'b1;
            state_in     = ST_DTV;
         end
         ST_DTV: begin
            cmd.mul_sel  = MS_DTV;
            cmd.sub_prod = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.sat_acc = 1'b1;
            cmd.restart = 1'b1;
            cmd.upd_pos = 1'b1;
            state_in    = ST_DTA;
         end
         ST_DTA: begin
            cmd.mul_sel = MS_DTA;
            state_in    = ST_KP1;
         end
         ST_KP1: begin
            cmd.mul_sel = MS_KPOS;
            cmd.upd_vel = 1'b1;
            state_in    = ST_BV1;
         end
         ST_BV1: begin
            cmd.mul_sel  = MS_BVEL;
            cmd.sub_prod = 1'b1;
            state_in     = ST_SUB1;
         end
         ST_SUB1: begin
            cmd.sub_prod = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/aas_dpath.sv -----
module aas_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [aas_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic [aas_pkg::AXIS_W-1:0]            req_tuser,
   output logic [aas_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [aas_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  logic                                  csr_we,
   input  logic [aas_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [aas_pkg::DATA_W-1:0]            csr_wdata,
   input  aas_pkg::cmd_type                      cmd,
   output aas_pkg::stat_type                     stat
);
   import aas_pkg::*;

   // Configuration
   logic signed [DATA_W-1:0] kpm_ff, bpm_ff, imass_ff;
   logic        [DT_W-1:0]   dt_ff;

   // Captured request word
   logic        [AXIS_W-1:0] axis_ff;
   logic signed [DATA_W-1:0] dpos_ff, dvel_ff, apos_ff, avel_ff, force_ff, dforce_ff;

   // Per-axis deviation state
   logic signed [DATA_W-1:0] dev_pos_ff [AXES];
   logic signed [DATA_W-1:0] dev_vel_ff [AXES];
   logic        [AXES-1:0]   started_ff;

   // Working registers
   logic signed [DATA_W-1:0] pos_ff, vel_ff, acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [RND_W-1:0]  imf_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     clip_ff;

   // Output word
   logic        [AXIS_W-1:0] o_axis_ff;
   logic signed [DATA_W-1:0] o_pos_ff, o_vel_ff, o_acc_ff, o_force_ff;
   logic                     o_clip_ff;

   logic                     axis_ok;
   logic        [AXIS_W-1:0] ax_idx;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [MUL_A_W+DATA_W-1:0] prod_full;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [RND_W-1:0]  rnd;
   sat_type                  init_p, init_v, new_p, new_v, acc_s;
   sat_type                  fin_a, fin_p, fin_v;

   assign axis_ok      = (axis_ff < AXIS_W'(AXES));
   assign stat.axis_ok = axis_ok;
   assign ax_idx       = axis_ok ? axis_ff : '0;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kpm_ff   <= '0;
         bpm_ff   <= '0;
         imass_ff <= DATA_W'(65536);
         dt_ff    <= DT_W'(66);
      end else if (csr_we) begin
         case (csr_addr)
            REG_KPM:   kpm_ff   <= csr_wdata;
            REG_BPM:   bpm_ff   <= csr_wdata;
            REG_IMASS: imass_ff <= csr_wdata;
            REG_DT:    dt_ff    <= csr_wdata[DT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         axis_ff   <= req_tuser;
         dpos_ff   <= req_tdata[0*DATA_W +: DATA_W];
         dvel_ff   <= req_tdata[1*DATA_W +: DATA_W];
         apos_ff   <= req_tdata[2*DATA_W +: DATA_W];
         avel_ff   <= req_tdata[3*DATA_W +: DATA_W];
         force_ff  <= req_tdata[4*DATA_W +: DATA_W];
         dforce_ff <= req_tdata[5*DATA_W +: DATA_W];
      end
   end

   // Shared multiplier operand select, product registered
   always_comb begin
      case (cmd.mul_sel)
         MS_IMF: begin
            mul_a = MUL_A_W'(imass_ff);
            mul_b = force_ff;
         end
         MS_KPOS: begin
            mul_a = MUL_A_W'(kpm_ff);
            mul_b = pos_ff;
         end
         MS_BVEL: begin
            mul_a = MUL_A_W'(bpm_ff);
            mul_b = vel_ff;
         end
         MS_DTV: begin
            mul_a = $signed({2'b00, dt_ff});
            mul_b = vel_ff;
         end
         MS_DTA: begin
            mul_a = $signed({2'b00, dt_ff});
            mul_b = acc_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[PROD_W-1:0];
   end

   // Round half up to Q16.16
   assign prod_rnd = prod_ff + RND_HALF;
   assign rnd      = prod_rnd[RND_W+15:16];

   // Saturating adders
   assign init_p = sat32(SUM_W'(apos_ff) - SUM_W'(dpos_ff));
   assign init_v = sat32(SUM_W'(avel_ff) - SUM_W'(dvel_ff));
   assign new_p  = sat32(SUM_W'(pos_ff) + SUM_W'(rnd));
   assign new_v  = sat32(SUM_W'(vel_ff) + SUM_W'(rnd));
   assign acc_s  = sat32(sum_ff);
   assign fin_a  = sat32(sum_ff);
   assign fin_p  = sat32(SUM_W'(dpos_ff) + SUM_W'(pos_ff));
   assign fin_v  = sat32(SUM_W'(dvel_ff) + SUM_W'(vel_ff));

   // Working state of the item in flight
   always_ff @(posedge clock) begin
      if (cmd.load_state) begin
         if (started_ff[ax_idx]) begin
            pos_ff  <= dev_pos_ff[ax_idx];
            vel_ff  <= dev_vel_ff[ax_idx];
            clip_ff <= 1'b0;
         end else begin
            pos_ff  <= init_p.val;
            vel_ff  <= init_v.val;
            clip_ff <= init_p.clip | init_v.clip;
         end
      end else begin
         if (cmd.upd_pos) begin
            pos_ff <= new_p.val;
         end
         if (cmd.upd_vel) begin
            vel_ff <= new_v.val;
         end
         clip_ff <= clip_ff | (cmd.upd_pos & new_p.clip) | (cmd.upd_vel & new_v.clip)
                    | (cmd.sat_acc & acc_s.clip);
      end
      if (cmd.sat_acc) begin
         acc_ff <= acc_s.val;
      end
      if (cmd.ld_imf) begin
         imf_ff <= rnd;
         sum_ff <= SUM_W'(rnd);
      end else if (cmd.restart) begin
         sum_ff <= SUM_W'(imf_ff);
      end else if (cmd.sub_prod) begin
         sum_ff <= sum_ff - SUM_W'(rnd);
      end
   end

   // Deviation store, seeded on the first word of each axis
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
      end else if (cmd.finish && axis_ok) begin
         started_ff[ax_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && axis_ok) begin
         dev_pos_ff[ax_idx] <= pos_ff;
         dev_vel_ff[ax_idx] <= vel_ff;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         o_axis_ff  <= axis_ff;
         o_force_ff <= dforce_ff;
         if (axis_ok) begin
            o_pos_ff  <= fin_p.val;
            o_vel_ff  <= fin_v.val;
            o_acc_ff  <= fin_a.val;
            o_clip_ff <= clip_ff | fin_p.clip | fin_v.clip | fin_a.clip;
         end else begin
            o_pos_ff  <= dpos_ff;
            o_vel_ff  <= dvel_ff;
            o_acc_ff  <= '0;
            o_clip_ff <= 1'b0;
         end
      end
   end

   assign rsp_tdata = {o_force_ff, o_acc_ff, o_vel_ff, o_pos_ff};
   assign rsp_tuser = {o_clip_ff, o_axis_ff};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int RUN_LIMIT  = 500000;
   localparam int SEG_WORDS  = 240;
   localparam int SEG_COUNT  = 8;
   localparam int PRINT_CAP  = 40;
   localparam longint Q_MAX  = 64'sd2147483647;
   localparam longint Q_MIN  = -64'sd2147483648;

   // One request word: axis plus six Q16.16 fields
   typedef struct {
      logic [aas_pkg::AXIS_W-1:0] axis;
      logic [31:0]                des_pos;
      logic [31:0]                des_vel;
      logic [31:0]                act_pos;
      logic [31:0]                act_vel;
      logic [31:0]                act_frc;
      logic [31:0]                des_frc;
   } admit_req_type;

   // One response word
   typedef struct {
      logic [aas_pkg::AXIS_W-1:0] axis;
      logic [31:0]                cmd_pos;
      logic [31:0]                cmd_vel;
      logic [31:0]                cmd_acc;
      logic [31:0]                cmd_frc;
      logic                       clipped;
   } cmd_word_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [aas_pkg::REQ_DATA_W-1:0]       req_tdata = '0;
   logic [aas_pkg::AXIS_W-1:0]           req_tuser = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [aas_pkg::RSP_DATA_W-1:0]       rsp_tdata;
   logic [aas_pkg::RSP_USER_W-1:0]       rsp_tuser;
   logic                                 csr_we = 1'b0;
   logic [aas_pkg::CSR_ADDR_W-1:0]       csr_addr = '0;
   logic [aas_pkg::DATA_W-1:0]           csr_wdata = '0;

   admit_req_type  req_pending_q[$];
   cmd_word_type   cmd_due_q[$];
   admit_req_type  req_on_bus;
   logic        req_taken = 1'b0;
   int          err_count = 0;
   int          cycle_cnt = 0;
   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;

   // Controller mirror: registers and per-axis deviation state
   longint      mir_kpm = 0;
   longint      mir_bpm = 0;
   longint      mir_imass = 65536;
   longint      mir_dt = 66;
   longint      mir_dev_pos[aas_pkg::AXES];
   longint      mir_dev_vel[aas_pkg::AXES];
   bit          mir_seeded[aas_pkg::AXES];
   bit          mir_clip;

   admittance_axis_step_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Q16.16 product, exact, rounded half up (arithmetic shift floors)
   function automatic longint q_mul(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return p >>> 16;
   endfunction

   function automatic longint q_sat(longint v);
      if (v > Q_MAX) begin
         mir_clip = 1'b1;
         return Q_MAX;
      end
      if (v < Q_MIN) begin
         mir_clip = 1'b1;
         return Q_MIN;
      end
      return v;
   endfunction

   function automatic longint model_accel(longint frc, longint pos, longint vel);
      return q_mul(mir_imass, frc) - q_mul(mir_kpm, pos) - q_mul(mir_bpm, vel);
   endfunction

   function automatic longint sx(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   // Euler step of one axis; returns the response word it should produce
   function automatic cmd_word_type advance_axis(admit_req_type r);
      cmd_word_type w;
      longint    dpos, dvel, frc, pos, vel, acc, npos, nvel;
      int        a;
      mir_clip  = 1'b0;
      dpos      = sx(r.des_pos);
      dvel      = sx(r.des_vel);
      frc       = sx(r.act_frc);
      w.axis    = r.axis;
      w.cmd_frc = r.des_frc;
      if (r.axis < aas_pkg::AXES) begin
         a = r.axis;
         // first word of an axis seeds the deviation from the measurement
         if (!mir_seeded[a]) begin
            mir_dev_pos[a] = q_sat(sx(r.act_pos) - dpos);
            mir_dev_vel[a] = q_sat(sx(r.act_vel) - dvel);
            mir_seeded[a]  = 1'b1;
         end
         pos  = mir_dev_pos[a];
         vel  = mir_dev_vel[a];
         acc  = q_sat(model_accel(frc, pos, vel));
         npos = q_sat(pos + q_mul(mir_dt, vel));
         nvel = q_sat(vel + q_mul(mir_dt, acc));
         mir_dev_pos[a] = npos;
         mir_dev_vel[a] = nvel;
         w.cmd_acc = 32'(q_sat(model_accel(frc, npos, nvel)));
         w.cmd_pos = 32'(q_sat(dpos + npos));
         w.cmd_vel = 32'(q_sat(dvel + nvel));
      end else begin
         // axis out of range: pass-through, no state change
         w.cmd_pos = r.des_pos;
         w.cmd_vel = r.des_vel;
         w.cmd_acc = '0;
      end
      w.clipped = mir_clip;
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      if (err_count < PRINT_CAP)
         $display("%0t ns: ERROR %s", $time, what);
      err_count++;
   endtask

   // Request driver: present next word once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_on_bus = req_pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= req_on_bus.axis;
            req_tdata  <= {req_on_bus.des_frc, req_on_bus.act_frc, req_on_bus.act_vel,
                           req_on_bus.act_pos, req_on_bus.des_vel, req_on_bus.des_pos};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: predict on request accept, check on response accept
   always @(posedge clock) begin : bus_watch
      cmd_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            cmd_due_q.push_back(advance_axis(req_on_bus));
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_due_q.size() == 0) begin
               report_mismatch($sformatf("response word with none pending, axis %0d",
                                         rsp_tuser[2:0]));
            end else begin
               want = cmd_due_q.pop_front();
               if (rsp_tuser[2:0] !== want.axis)
                  report_mismatch($sformatf("out_axis %0d, want %0d",
                                            rsp_tuser[2:0], want.axis));
               if (rsp_tdata[31:0] !== want.cmd_pos)
                  report_mismatch($sformatf("axis %0d cmd_pos %h, want %h",
                                            want.axis, rsp_tdata[31:0], want.cmd_pos));
               if (rsp_tdata[63:32] !== want.cmd_vel)
                  report_mismatch($sformatf("axis %0d cmd_vel %h, want %h",
                                            want.axis, rsp_tdata[63:32], want.cmd_vel));
               if (rsp_tdata[95:64] !== want.cmd_acc)
                  report_mismatch($sformatf("axis %0d cmd_acc %h, want %h",
                                            want.axis, rsp_tdata[95:64], want.cmd_acc));
               if (rsp_tdata[127:96] !== want.cmd_frc)
                  report_mismatch($sformatf("axis %0d cmd_force %h, want %h",
                                            want.axis, rsp_tdata[127:96], want.cmd_frc));
               if (rsp_tuser[3] !== want.clipped)
                  report_mismatch($sformatf("axis %0d clipped %b, want %b",
                                            want.axis, rsp_tuser[3], want.clipped));
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == RUN_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_word(input logic [2:0] ax, input logic [31:0] dp, input logic [31:0] dv,
                            input logic [31:0] ap, input logic [31:0] av,
                            input logic [31:0] af, input logic [31:0] df);
      admit_req_type r;
      r.axis = ax;
      r.des_pos = dp;
      r.des_vel = dv;
      r.act_pos = ap;
      r.act_vel = av;
      r.act_frc = af;
      r.des_frc = df;
      req_pending_q.push_back(r);
   endtask

   // Q16.16 value: extremes, small magnitudes, or anything
   function automatic logic [31:0] pick_q16();
      int v;
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
         3, 4, 5: begin
            v = int'($urandom_range(524287)) - 262144;
            return v;
         end
         default: return $urandom();
      endcase
   endfunction

   // Everything sent and answered; sampled at the rising edge
   task automatic wait_idle();
      @(posedge clock);
      while (req_pending_q.size() != 0 || req_tvalid || cmd_due_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         aas_pkg::REG_KPM:   mir_kpm   = sx(val);
         aas_pkg::REG_BPM:   mir_bpm   = sx(val);
         aas_pkg::REG_IMASS: mir_imass = sx(val);
         aas_pkg::REG_DT:    mir_dt    = longint'(val[30:0]);
         default: ;
      endcase
   endtask

   task automatic load_setting(input logic [31:0] kpm, input logic [31:0] bpm,
                               input logic [31:0] imass, input logic [31:0] dt);
      write_reg(aas_pkg::REG_KPM, kpm);
      write_reg(aas_pkg::REG_BPM, bpm);
      write_reg(aas_pkg::REG_IMASS, imass);
      write_reg(aas_pkg::REG_DT, dt);
   endtask

   // Stimulus
   initial begin : stim
      logic [2:0] ax;
      for (int i = 0; i < aas_pkg::AXES; i++) begin
         mir_dev_pos[i] = 0;
         mir_dev_vel[i] = 0;
         mir_seeded[i]  = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under reset register values.
      // Seeding that saturates high and low, then plain seeds.
      push_word(3'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
      push_word(3'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff);
      push_word(3'd2, 32'h0001_0000, 32'h0000_8000, 32'h0001_8000, 0,
                32'h0002_0000, 32'hffff_0000);
      push_word(3'd3, 0, 0, 0, 0, 0, 0);
      push_word(3'd4, '1, '1, '1, '1, '1, '1);
      push_word(3'd5, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
      // axis indexes past the last axis
      push_word(3'd6, 32'h7fff_ffff, 32'h8000_0000, '1, 0, 32'h7fff_ffff, 32'h1234_5678);
      push_word(3'd7, 32'h8000_0000, 32'h7fff_ffff, 0, '1, 32'h8000_0000, 32'hedcb_a987);
      // started axes: command sums and force terms at the limits
      push_word(3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0);
      push_word(3'd1, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000, '1);
      push_word(3'd2, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_word(3'd3, '1, 32'h0000_0001, 0, 0, 32'h8000_0000, 0);
      push_word(3'd4, 32'h8000_0000, 32'h7fff_ffff, 0, 0, '1, 32'h8000_0000);
      push_word(3'd5, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h0000_0001, 1);
      push_word(3'd0, 32'h8000_0000, 32'h8000_0000, '1, '1, 0, 0);
      push_word(3'd1, 32'h7fff_ffff, 32'h7fff_ffff, '1, '1, 0, 0);
      push_word(3'd2, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                32'h5555_5555, 32'haaaa_aaaa);
      push_word(3'd3, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 32'h5555_5555);
      push_word(3'd6, 0, 0, 0, 0, 0, 0);
      push_word(3'd7, '1, '1, '1, '1, '1, '1);

      // Random segments: a register setting and an idle mode each
      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         wait_idle();
         case (seg)
            0: load_setting(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
            1: load_setting(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000);
            2: load_setting(32'h0064_0000, 32'h0014_0000, 32'h0000_8000, 32'h0000_0042);
            3: load_setting(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
            default: load_setting(pick_q16(), pick_q16(), pick_q16(),
                                  $urandom_range(1) ? $urandom() : $urandom_range(4096));
         endcase
         case (seg % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 53; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_gap_pct = 32; rsp_stall_pct = 32; end
         endcase
         for (int n = 0; n < SEG_WORDS; n++) begin
            ax = ($urandom_range(9) != 0) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
            push_word(ax, pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                      pick_q16(), pick_q16());
         end
      end

      // Drain, then let any stray word show up
      wait_idle();
      repeat (20) @(negedge clock);
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
